@@ rtl/btet_pkg.sv @@
// Shared types, codes and default sizes for the trigger box tracker.
package btet_pkg;

    localparam int MAX_TRIGGERS_DEF = 32;
    localparam int NUM_PLAYERS_DEF  = 2;
    localparam int COORD_BITS_DEF   = 16;

    localparam int FIELD_W    = 16;
    localparam int CMDQ_DEPTH = 2;
    localparam int RESQ_DEPTH = 2;
    localparam int CFG_IDX_W  = 2;

    localparam logic [1:0] MODE_REGISTER = 2'd0;
    localparam logic [1:0] MODE_CLEAR    = 2'd1;
    localparam logic [1:0] MODE_UPDATE   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ENTER_EN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_EXIT_EN  = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        KIND_ENTER      = 3'd0,
        KIND_EXIT       = 3'd1,
        KIND_DONE       = 3'd2,
        KIND_REGISTERED = 3'd3,
        KIND_FULL       = 3'd4,
        KIND_CLEARED    = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        OP_REGISTER,
        OP_CLEAR,
        OP_UPDATE,
        OP_IGNORE
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_bstate;

    typedef struct packed {
        logic [1:0]         mode;
        logic               player;
        logic [FIELD_W-1:0] box_min_x;
        logic [FIELD_W-1:0] box_min_y;
        logic [FIELD_W-1:0] box_max_x;
        logic [FIELD_W-1:0] box_max_y;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [4:0] trigger_index;
        logic       player_slot;
        logic       last;
    } t_result;

    typedef struct packed {
        t_op      op;
        t_in_item item;
    } t_cmd;

endpackage

@@ rtl/btet_fifo.sv @@
// Small register queue used for commands and for results.
module btet_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output T     o_data
);
    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    T                r_mem [DEPTH];
    logic [PTRW-1:0] r_wptr, n_wptr;
    logic [PTRW-1:0] r_rptr, n_rptr;
    logic [CNTW-1:0] r_count, n_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTRW'(DEPTH - 1)) ? '0 : PTRW'(r_wptr + 1'b1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTRW'(DEPTH - 1)) ? '0 : PTRW'(r_rptr + 1'b1);
        end
        if (do_push && !do_pop) begin
            n_count = CNTW'(r_count + 1'b1);
        end else if (do_pop && !do_push) begin
            n_count = CNTW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

@@ rtl/btet_front.sv @@
// Front end: takes input items, decodes the mode and queues commands.
module btet_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  btet_pkg::t_in_item i_item,
    input  logic              i_pop,
    output logic              o_empty,
    output btet_pkg::t_cmd    o_cmd
);
    import btet_pkg::*;

    t_op  op;
    t_cmd cmd;
    logic q_full;
    logic enq;

    always_comb begin
        case (i_item.mode)
            MODE_REGISTER: op = OP_REGISTER;
            MODE_CLEAR:    op = OP_CLEAR;
            MODE_UPDATE:   op = OP_UPDATE;
            default:       op = OP_IGNORE;
        endcase
    end

    assign cmd.op   = op;
    assign cmd.item = i_item;
    assign o_full   = q_full;
    // unused mode is taken off the port but never queued
    assign enq      = i_push && !q_full && (op != OP_IGNORE);

    btet_fifo #(
        .T     (t_cmd),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (enq),
        .i_data  (cmd),
        .o_full  (q_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (o_cmd)
    );

endmodule

@@ rtl/btet_back.sv @@
// Back end: trigger table, inside flags and the per-trigger walk for updates.
module btet_back #(
    parameter int MAX_TRIGGERS = btet_pkg::MAX_TRIGGERS_DEF,
    parameter int NUM_PLAYERS  = btet_pkg::NUM_PLAYERS_DEF,
    parameter int COORD_BITS   = btet_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [btet_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                           i_cfg_data,
    input  logic                           i_cmd_empty,
    input  btet_pkg::t_cmd                 i_cmd,
    output logic                           o_cmd_pop,
    input  logic                           i_res_full,
    output logic                           o_res_push,
    output btet_pkg::t_result              o_res
);
    import btet_pkg::*;

    localparam int IW      = (MAX_TRIGGERS > 1) ? $clog2(MAX_TRIGGERS) : 1;
    localparam int CW      = $clog2(MAX_TRIGGERS + 1);
    localparam int PLW     = (NUM_PLAYERS > 1) ? $clog2(NUM_PLAYERS) : 1;
    localparam int SRC_W   = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int BOX_W   = 4 * COORD_BITS;

    function automatic logic signed [COORD_BITS-1:0] to_coord(input logic [FIELD_W-1:0] raw);
        logic signed [SRC_W-1:0] low;
        low = raw[SRC_W-1:0];
        return COORD_BITS'(low);
    endfunction

    function automatic logic axis_pass(
        input logic signed [COORD_BITS-1:0] tmin,
        input logic signed [COORD_BITS-1:0] tmax,
        input logic signed [COORD_BITS-1:0] pmin,
        input logic signed [COORD_BITS-1:0] pmax
    );
        logic a, b;
        a = ((tmin < pmin) || (tmin < pmax)) && ((tmax > pmin) || (tmax > pmax));
        b = ((pmin < tmin) || (pmax < tmin)) && ((pmin > tmax) || (pmax > tmax));
        return a || b;
    endfunction

    // trigger box memory, x/y min then x/y max
    logic [BOX_W-1:0]       r_boxes [MAX_TRIGGERS];
    logic [BOX_W-1:0]       r_rdata;
    logic [IW-1:0]          rd_addr;
    logic                   mem_we;
    logic [BOX_W-1:0]       in_box;

    logic [NUM_PLAYERS-1:0] r_flags [MAX_TRIGGERS];
    logic [NUM_PLAYERS-1:0] n_flags [MAX_TRIGGERS];
    logic [CW-1:0]          r_count, n_count;
    logic [IW-1:0]          r_idx, n_idx;
    logic [PLW-1:0]         r_player, n_player;
    logic [BOX_W-1:0]       r_pbox, n_pbox;
    logic                   r_en_enter, r_en_exit;
    t_bstate                r_state, n_state;

    logic                   upd_go;
    logic                   overlap, was;
    logic                   ev_enter, ev_exit, walk_stall, walk_end;

    assign in_box = {to_coord(i_cmd.item.box_min_x), to_coord(i_cmd.item.box_min_y),
                     to_coord(i_cmd.item.box_max_x), to_coord(i_cmd.item.box_max_y)};

    assign upd_go = (r_count != '0) && (r_en_enter || r_en_exit)
                    && (32'(i_cmd.item.player) < NUM_PLAYERS);

    assign overlap = axis_pass($signed(r_rdata[4*COORD_BITS-1 -: COORD_BITS]),
                               $signed(r_rdata[2*COORD_BITS-1 -: COORD_BITS]),
                               $signed(r_pbox[4*COORD_BITS-1 -: COORD_BITS]),
                               $signed(r_pbox[2*COORD_BITS-1 -: COORD_BITS]))
                  && axis_pass($signed(r_rdata[3*COORD_BITS-1 -: COORD_BITS]),
                               $signed(r_rdata[COORD_BITS-1:0]),
                               $signed(r_pbox[3*COORD_BITS-1 -: COORD_BITS]),
                               $signed(r_pbox[COORD_BITS-1:0]));
    assign was        = r_flags[r_idx][r_player];
    assign ev_enter   = overlap && !was && r_en_enter;
    assign ev_exit    = !overlap && was && r_en_exit;
    assign walk_stall = (ev_enter || ev_exit) && i_res_full;
    assign walk_end   = (CW'(r_idx) + 1'b1) == r_count;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty && !i_res_full && i_cmd.op == OP_UPDATE && upd_go) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (!walk_stall && walk_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_res_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '{kind: KIND_DONE, trigger_index: '0, player_slot: 1'b0, last: 1'b1};
        mem_we     = 1'b0;
        rd_addr    = '0;
        n_flags    = r_flags;
        n_count    = r_count;
        n_idx      = r_idx;
        n_player   = r_player;
        n_pbox     = r_pbox;
        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        OP_REGISTER: begin
                            o_res_push = 1'b1;
                            if (r_count >= CW'(MAX_TRIGGERS)) begin
                                o_res.kind = KIND_FULL;
                            end else begin
                                mem_we                 = 1'b1;
                                n_flags[IW'(r_count)]  = '0;
                                n_count                = CW'(r_count + 1'b1);
                                o_res.kind             = KIND_REGISTERED;
                                o_res.trigger_index    = 5'(r_count);
                            end
                        end
                        OP_CLEAR: begin
                            o_res_push = 1'b1;
                            o_res.kind = KIND_CLEARED;
                            n_count    = '0;
                            for (int i = 0; i < MAX_TRIGGERS; i++) begin
                                n_flags[i] = '0;
                            end
                        end
                        OP_UPDATE: begin
                            if (upd_go) begin
                                n_idx    = '0;
                                n_player = PLW'(i_cmd.item.player);
                                n_pbox   = in_box;
                            end else begin
                                o_res_push = 1'b1;
                            end
                        end
                        default: o_cmd_pop = 1'b1;
                    endcase
                end
            end
            ST_WALK: begin
                rd_addr = r_idx;
                if (!walk_stall) begin
                    if (ev_enter || ev_exit) begin
                        o_res_push                = 1'b1;
                        o_res.kind                = ev_enter ? KIND_ENTER : KIND_EXIT;
                        o_res.trigger_index       = 5'(r_idx);
                        o_res.player_slot         = r_player[0];
                        o_res.last                = 1'b0;
                        n_flags[r_idx][r_player]  = ev_enter;
                    end
                    if (!walk_end) begin
                        n_idx   = IW'(r_idx + 1'b1);
                        rd_addr = n_idx;
                    end
                end
            end
            ST_DONE: begin
                o_res_push = !i_res_full;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_en_enter <= 1'b0;
            r_en_exit  <= 1'b0;
            for (int i = 0; i < MAX_TRIGGERS; i++) begin
                r_flags[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_flags <= n_flags;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ENTER_EN: r_en_enter <= i_cfg_data;
                    REG_EXIT_EN:  r_en_exit  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_player <= n_player;
        r_pbox   <= n_pbox;
    end

    // registered read is addressed by the next trigger index, so its data lines up with the trigger under test
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_boxes[IW'(r_count)] <= in_box;
        end
        r_rdata <= r_boxes[rd_addr];
    end

endmodule

@@ rtl/box_trigger_enter_exit_tracker.sv @@
// Trigger box tracker: table of up to MAX_TRIGGERS boxes with per-player inside flags.
// Items go in through a two-deep command queue and results come out of a two-deep
// result queue, so either side may stall without holding the other. Register and
// clear items are handled in the back end idle state; an update with stored triggers,
// an enable set and a valid player is dispatched, walked one trigger per cycle
// (stalled while an event meets a full result queue) through the registered box
// read, then done; any other update gets a done result only. An unused mode is
// absorbed at the input. Enable registers are written via the always-ready cfg port.
module box_trigger_enter_exit_tracker #(
    parameter int MAX_TRIGGERS = btet_pkg::MAX_TRIGGERS_DEF,
    parameter int NUM_PLAYERS  = btet_pkg::NUM_PLAYERS_DEF,
    parameter int COORD_BITS   = btet_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  btet_pkg::t_in_item             i_item,
    output logic                           empty,
    input  logic                           pop,
    output btet_pkg::t_result              o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [btet_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                           i_cfg_data
);
    import btet_pkg::*;

    t_cmd    cmd;
    logic    cmd_empty, cmd_pop;
    t_result res;
    logic    res_push, res_full;

    assign o_cfg_ready = 1'b1;

    btet_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (i_item),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_cmd   (cmd)
    );

    btet_back #(
        .MAX_TRIGGERS (MAX_TRIGGERS),
        .NUM_PLAYERS  (NUM_PLAYERS),
        .COORD_BITS   (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    btet_fifo #(
        .T     (t_result),
        .DEPTH (RESQ_DEPTH)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_result)
    );

endmodule

@@ rtl/btet_checker.sv @@
// Port-level checks for the trigger box tracker, bound to the top level.
module btet_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              push,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input btet_pkg::t_result o_result
);

    // result queue comes up empty and input queue not full out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // results only drain by a pop transfer
    a_empty_by_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(empty) |-> $past(pop))
        else $error("result queue emptied without a pop");

    // input side only fills by a push transfer
    a_full_by_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(full) |-> $past(push))
        else $error("input queue filled without a push");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("waiting result changed");

endmodule

bind box_trigger_enter_exit_tracker btet_checker u_btet_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
